// ===== rtl/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// maf_pkg
// shared types and constants for the mail address finder
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int MAX_LINE_DEF = 4096;

    // character queue between front and back
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam int CHAR_W  = 16;
    localparam int START_W = 12;
    localparam int BEGIN_W = 12;
    localparam int END_W   = 13;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic [CHAR_W-1:0] CH_AT    = 16'd64;
    localparam logic [CHAR_W-1:0] CH_DOT   = 16'd46;
    localparam logic [CHAR_W-1:0] CH_TILDE = 16'd126;
    localparam logic [CHAR_W-1:0] CH_UNDER = 16'd95;
    localparam logic [CHAR_W-1:0] CH_BSL   = 16'd92;
    localparam logic [CHAR_W-1:0] CH_EQ    = 16'd61;
    localparam logic [CHAR_W-1:0] CH_HASH  = 16'd35;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 16'd43;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 16'd97;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 16'd122;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'd65;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 16'd90;
    localparam logic [CHAR_W-1:0] CH_DASH    = 16'd45;
    localparam logic [CHAR_W-1:0] CH_COLON   = 16'd58;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 16'd36;
    localparam logic [CHAR_W-1:0] CH_AMP     = 16'd38;

    typedef struct packed {
        logic mail;
        logic at;
        logic dot;
    } char_class_t;

    typedef struct packed {
        logic                last;
        logic [START_W-1:0]  search_start;
        char_class_t         cls;
    } fq_entry_t;

    typedef struct packed {
        logic      valid;
        fq_entry_t entry;
    } fq_push_t;

endpackage

// ===== rtl/maf_front.sv =====
// ----------------------------------------------------------------------------
// maf_front
// accepts characters and classifies them for the back end
// ----------------------------------------------------------------------------
module maf_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [maf_pkg::S_DATA_W-1:0] s_tdata,  // char_code[15:0], search_start[27:16]
    input  logic                        s_tlast,   // last_char
    input  logic                        q_full,
    output maf_pkg::fq_push_t           push
);
    import maf_pkg::*;

    logic [CHAR_W-1:0] c;
    char_class_t       cls;

    assign c = s_tdata[CHAR_W-1:0];

    always_comb
    begin
        cls.mail = c inside {CH_TILDE, [CH_LOWER_A:CH_LOWER_Z], CH_UNDER,
                             [CH_UPPER_A:CH_UPPER_Z], CH_BSL, [CH_DASH:CH_COLON],
                             CH_EQ, [CH_DOLLAR:CH_AMP], CH_HASH, CH_PLUS};
        cls.at   = (c == CH_AT);
        cls.dot  = (c == CH_DOT);
    end

    assign s_tready = !q_full;

    always_comb
    begin
        push.valid              = s_tvalid && !q_full;
        push.entry.last         = s_tlast;
        push.entry.search_start = s_tdata[CHAR_W+START_W-1:CHAR_W];
        push.entry.cls          = cls;
    end

endmodule

// ===== rtl/maf_queue.sv =====
// ----------------------------------------------------------------------------
// maf_queue
// short fifo of classified characters between front and back
// ----------------------------------------------------------------------------
module maf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  maf_pkg::fq_push_t   push,
    output logic                full,
    output logic                q_valid,
    output maf_pkg::fq_entry_t  q_entry,
    input  logic                q_ready
);
    import maf_pkg::*;

    fq_entry_t        mem [FQ_DEPTH];
    logic [FQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FQ_CW-1:0] count_reg, count_next;
    logic             pop;

    assign full    = (count_reg == FQ_CW'(FQ_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == FQ_AW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FQ_AW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== rtl/maf_back.sv =====
// ----------------------------------------------------------------------------
// maf_back
// per-line scan state and result register
// ----------------------------------------------------------------------------
module maf_back #(
    parameter int MAX_LINE = maf_pkg::MAX_LINE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  maf_pkg::fq_entry_t           q_entry,
    output logic                         q_ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [maf_pkg::M_DATA_W-1:0] m_tdata,  // begin_pos[11:0], end_pos[24:12], overlong[25]
    output logic                         m_tuser   // found
);
    import maf_pkg::*;

    localparam int LPW = $clog2(MAX_LINE + 1);
    localparam int PW  = $clog2(MAX_LINE);

    logic [LPW-1:0]     line_pos_reg,    line_pos_next;
    logic [PW-1:0]      run_begin_reg,   run_begin_next;
    logic               prev_mail_reg,   prev_mail_next;
    logic               in_cand_reg,     in_cand_next;
    logic [PW-1:0]      cand_begin_reg,  cand_begin_next;
    logic               dot_seen_reg,    dot_seen_next;
    logic               line_done_reg,   line_done_next;
    logic [START_W-1:0] start_latch_reg, start_latch_next;
    logic               overflowed_reg,  overflowed_next;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [BEGIN_W-1:0] out_begin_reg;
    logic [END_W-1:0]   out_end_reg;
    logic               out_overlong_reg;

    logic               pop;
    logic               emit;
    logic               e_found;
    logic [PW-1:0]      e_begin_raw;
    logic [LPW-1:0]     e_end_raw;
    logic               e_overlong;
    logic [START_W-1:0] start_eff;
    logic               start_ok;
    logic               at_limit;
    logic [PW+BEGIN_W-1:0] begin_wide;
    logic [LPW+END_W-1:0]  end_wide;

    assign q_ready = !out_valid_reg || m_tready;
    assign pop     = q_valid && q_ready;

    // search start is taken with the first character of a line
    assign start_eff = (line_pos_reg == '0) ? q_entry.search_start : start_latch_reg;
    assign start_ok  = {{START_W{1'b0}}, line_pos_reg} >= {{LPW{1'b0}}, start_eff};
    assign at_limit  = line_pos_reg >= LPW'(MAX_LINE);

    always_comb
    begin
        line_pos_next    = line_pos_reg;
        run_begin_next   = run_begin_reg;
        prev_mail_next   = prev_mail_reg;
        in_cand_next     = in_cand_reg;
        cand_begin_next  = cand_begin_reg;
        dot_seen_next    = dot_seen_reg;
        line_done_next   = line_done_reg;
        start_latch_next = start_latch_reg;
        overflowed_next  = overflowed_reg;
        emit             = 1'b0;
        e_found          = 1'b0;
        e_begin_raw      = '0;
        e_end_raw        = '0;
        e_overlong       = 1'b0;

        if (pop)
        begin
            start_latch_next = start_eff;
            if (at_limit)
            begin
                overflowed_next = 1'b1;
            end
            else if (!line_done_reg)
            begin
                if (in_cand_reg)
                begin
                    if (q_entry.cls.mail)
                    begin
                        if (q_entry.cls.dot)
                        begin
                            dot_seen_next = 1'b1;
                        end
                    end
                    else
                    begin
                        in_cand_next = 1'b0;
                        if (dot_seen_reg)
                        begin
                            line_done_next = 1'b1;
                            emit           = 1'b1;
                            e_found        = 1'b1;
                            e_begin_raw    = cand_begin_reg;
                            e_end_raw      = line_pos_reg;
                            e_overlong     = overflowed_reg;
                        end
                    end
                end
                // the closing character of a rejected candidate may open a new one
                if (!line_done_next && !in_cand_next && q_entry.cls.at &&
                    prev_mail_reg && start_ok)
                begin
                    in_cand_next    = 1'b1;
                    cand_begin_next = run_begin_reg;
                    dot_seen_next   = 1'b0;
                end
                if (q_entry.cls.mail && !prev_mail_reg)
                begin
                    run_begin_next = line_pos_reg[PW-1:0];
                end
                prev_mail_next = q_entry.cls.mail;
                line_pos_next  = line_pos_reg + 1'b1;
            end

            if (q_entry.last)
            begin
                if (!line_done_next)
                begin
                    emit        = 1'b1;
                    e_found     = in_cand_next && dot_seen_next;
                    e_begin_raw = e_found ? cand_begin_next : '0;
                    e_end_raw   = e_found ? line_pos_next : '0;
                    e_overlong  = overflowed_next;
                end
                line_pos_next    = '0;
                run_begin_next   = '0;
                prev_mail_next   = 1'b0;
                in_cand_next     = 1'b0;
                cand_begin_next  = '0;
                dot_seen_next    = 1'b0;
                line_done_next   = 1'b0;
                start_latch_next = '0;
                overflowed_next  = 1'b0;
            end
        end
    end

    // positions are masked to the result field widths
    assign begin_wide = {{BEGIN_W{1'b0}}, e_begin_raw};
    assign end_wide   = {{END_W{1'b0}}, e_end_raw};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_pos_reg    <= '0;
            run_begin_reg   <= '0;
            prev_mail_reg   <= 1'b0;
            in_cand_reg     <= 1'b0;
            cand_begin_reg  <= '0;
            dot_seen_reg    <= 1'b0;
            line_done_reg   <= 1'b0;
            start_latch_reg <= '0;
            overflowed_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_pos_reg    <= line_pos_next;
            run_begin_reg   <= run_begin_next;
            prev_mail_reg   <= prev_mail_next;
            in_cand_reg     <= in_cand_next;
            cand_begin_reg  <= cand_begin_next;
            dot_seen_reg    <= dot_seen_next;
            line_done_reg   <= line_done_next;
            start_latch_reg <= start_latch_next;
            overflowed_reg  <= overflowed_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_found_reg    <= e_found;
            out_begin_reg    <= begin_wide[BEGIN_W-1:0];
            out_end_reg      <= end_wide[END_W-1:0];
            out_overlong_reg <= e_overlong;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{(M_DATA_W - BEGIN_W - END_W - 1){1'b0}},
                       out_overlong_reg, out_end_reg, out_begin_reg};

endmodule

// ===== rtl/mail_address_finder.sv =====
// ----------------------------------------------------------------------------
// mail_address_finder
// finds the first mail address of a streamed line of 16-bit characters
// ----------------------------------------------------------------------------
// result path: the character that decides a line's result is written into the queue,
//   then the back-end step loads the result register from it
// throughput: one character per cycle unless output stalls, set by the single-step scan update
// reset: clears the character queue, the line state and the output valid;
//   no clearing pass, the block is ready for characters straight out of reset
module mail_address_finder #(
    parameter int MAX_LINE = maf_pkg::MAX_LINE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [maf_pkg::S_DATA_W-1:0] s_tdata,  // char_code[15:0], search_start[27:16]
    input  logic                         s_tlast,  // last_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [maf_pkg::M_DATA_W-1:0] m_tdata,  // begin_pos[11:0], end_pos[24:12], overlong[25]
    output logic                         m_tuser   // found
);
    import maf_pkg::*;

    fq_push_t  push;
    logic      q_full;
    logic      q_valid;
    logic      q_ready;
    fq_entry_t q_entry;

    maf_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push)
    );

    maf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_ready (q_ready)
    );

    maf_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/maf_checker.sv =====
// ----------------------------------------------------------------------------
// maf_checker
// port-level checks for the mail address finder
// ----------------------------------------------------------------------------
module maf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [maf_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import maf_pkg::*;

    // a stalled result keeps its content
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a not-found result carries zero positions
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[BEGIN_W+END_W-1:0] == '0)
        else $error("not-found result with nonzero positions");

    // padding bits above the result fields stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:BEGIN_W+END_W+1] == '0)
        else $error("result padding not zero");

    // nothing is presented while reset is held
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind mail_address_finder maf_checker u_maf_checker (.*);
